>>> sv/mpi_umq_pkg.sv
// shared types and constants for the unexpected-message match queue
package mpi_umq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int SRC_W    = 16;
    localparam int TAG_W    = 31;
    localparam int COMM_W   = 8;
    localparam int BYTES_W  = 31;
    localparam int HANDLE_W = 8;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_PROBE   = 2'd1;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic load;
        logic match;
        logic pick;
        logic commit;
    } umq_cmd_t;

    typedef struct packed {
        logic new_insert;
    } umq_stat_t;

endpackage

>>> sv/mpi_umq_ctrl.sv
// controller state machine for the unexpected-message match queue
module mpi_umq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  mpi_umq_pkg::umq_stat_t stat,
    output mpi_umq_pkg::umq_cmd_t  cmd,
    output logic                   busy,
    output logic                   done
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_PICK  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.new_insert ? S_FIN : S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.commit = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_fin_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> done)
        else $error("result strobe missing after commit");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not start work");

endmodule

>>> sv/mpi_umq_dp.sv
// datapath of the unexpected-message match queue: entries, match, pick, compaction
module mpi_umq_dp #(
    parameter int QUEUE_DEPTH = mpi_umq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpi_umq_pkg::umq_cmd_t               cmd,
    output mpi_umq_pkg::umq_stat_t              stat,
    input  logic [mpi_umq_pkg::OP_W-1:0]        operation,
    input  logic [mpi_umq_pkg::SRC_W-1:0]       src_rank,
    input  logic                                any_source,
    input  logic [mpi_umq_pkg::TAG_W-1:0]       tag_value,
    input  logic                                any_tag,
    input  logic [mpi_umq_pkg::COMM_W-1:0]      comm_id,
    input  logic [mpi_umq_pkg::BYTES_W-1:0]     msg_bytes,
    input  logic [mpi_umq_pkg::BYTES_W-1:0]     request_bytes,
    input  logic [mpi_umq_pkg::HANDLE_W-1:0]    payload_handle,
    output logic [mpi_umq_pkg::ST_W-1:0]        status_code,
    output logic                                found,
    output logic [mpi_umq_pkg::SRC_W-1:0]       out_source,
    output logic [mpi_umq_pkg::TAG_W-1:0]       out_tag,
    output logic [mpi_umq_pkg::BYTES_W-1:0]     out_bytes,
    output logic [mpi_umq_pkg::BYTES_W-1:0]     copy_bytes,
    output logic [mpi_umq_pkg::HANDLE_W-1:0]    out_handle
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // latched request
    logic [mpi_umq_pkg::OP_W-1:0]     op_reg;
    logic [mpi_umq_pkg::SRC_W-1:0]    src_reg;
    logic                             anys_reg;
    logic [mpi_umq_pkg::TAG_W-1:0]    tag_reg;
    logic                             anyt_reg;
    logic [mpi_umq_pkg::COMM_W-1:0]   comm_reg;
    logic [mpi_umq_pkg::BYTES_W-1:0]  mbytes_reg;
    logic [mpi_umq_pkg::BYTES_W-1:0]  rbytes_reg;
    logic [mpi_umq_pkg::HANDLE_W-1:0] handle_reg;

    // queue entries, oldest at index 0
    logic [mpi_umq_pkg::SRC_W-1:0]    ent_src_reg    [QUEUE_DEPTH];
    logic [mpi_umq_pkg::TAG_W-1:0]    ent_tag_reg    [QUEUE_DEPTH];
    logic [mpi_umq_pkg::COMM_W-1:0]   ent_comm_reg   [QUEUE_DEPTH];
    logic [mpi_umq_pkg::BYTES_W-1:0]  ent_bytes_reg  [QUEUE_DEPTH];
    logic [mpi_umq_pkg::HANDLE_W-1:0] ent_handle_reg [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]           vld_reg;
    logic [CW-1:0]                    cnt_reg;

    logic [QUEUE_DEPTH-1:0]           match_reg;
    logic [QUEUE_DEPTH-1:0]           hit_reg;
    logic                             any_hit_reg;

    logic [mpi_umq_pkg::ST_W-1:0]     status_code_reg;
    logic                             found_reg;
    logic [mpi_umq_pkg::SRC_W-1:0]    out_source_reg;
    logic [mpi_umq_pkg::TAG_W-1:0]    out_tag_reg;
    logic [mpi_umq_pkg::BYTES_W-1:0]  out_bytes_reg;
    logic [mpi_umq_pkg::BYTES_W-1:0]  copy_bytes_reg;
    logic [mpi_umq_pkg::HANDLE_W-1:0] out_handle_reg;

    logic [QUEUE_DEPTH-1:0]           match_next;
    logic [QUEUE_DEPTH-1:0]           shift_mask;
    logic [mpi_umq_pkg::SRC_W-1:0]    sel_src;
    logic [mpi_umq_pkg::TAG_W-1:0]    sel_tag;
    logic [mpi_umq_pkg::BYTES_W-1:0]  sel_bytes;
    logic [mpi_umq_pkg::HANDLE_W-1:0] sel_handle;
    logic                             is_insert;
    logic                             is_search;
    logic                             is_consume;
    logic                             full;
    logic                             do_insert;
    logic                             do_remove;
    logic [mpi_umq_pkg::BYTES_W-1:0]  min_bytes;

    assign stat.new_insert = (operation == mpi_umq_pkg::OP_INSERT);

    assign is_insert  = (op_reg == mpi_umq_pkg::OP_INSERT);
    assign is_consume = (op_reg == mpi_umq_pkg::OP_CONSUME);
    assign is_search  = (op_reg == mpi_umq_pkg::OP_PROBE) || is_consume;
    assign full       = (cnt_reg == CW'(QUEUE_DEPTH));
    assign do_insert  = cmd.commit && is_insert && !full;
    assign do_remove  = cmd.commit && is_consume && any_hit_reg;
    assign shift_mask = ~(hit_reg - QUEUE_DEPTH'(1));
    assign min_bytes  = (rbytes_reg < sel_bytes) ? rbytes_reg : sel_bytes;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match_next[i] = vld_reg[i]
                && (anys_reg || ent_src_reg[i] == src_reg)
                && (anyt_reg || ent_tag_reg[i] == tag_reg)
                && (ent_comm_reg[i] == comm_reg);
        end
    end

    // one-hot readout of the picked entry
    always_comb
    begin
        sel_src    = '0;
        sel_tag    = '0;
        sel_bytes  = '0;
        sel_handle = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            sel_src    = sel_src    | (ent_src_reg[i]    & {mpi_umq_pkg::SRC_W{hit_reg[i]}});
            sel_tag    = sel_tag    | (ent_tag_reg[i]    & {mpi_umq_pkg::TAG_W{hit_reg[i]}});
            sel_bytes  = sel_bytes  | (ent_bytes_reg[i]  & {mpi_umq_pkg::BYTES_W{hit_reg[i]}});
            sel_handle = sel_handle
                       | (ent_handle_reg[i] & {mpi_umq_pkg::HANDLE_W{hit_reg[i]}});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            src_reg    <= src_rank;
            anys_reg   <= any_source;
            tag_reg    <= tag_value;
            anyt_reg   <= any_tag;
            comm_reg   <= comm_id;
            mbytes_reg <= msg_bytes;
            rbytes_reg <= request_bytes;
            handle_reg <= payload_handle;
        end
        if (cmd.match)
        begin
            match_reg <= match_next;
        end
        if (cmd.pick)
        begin
            hit_reg     <= match_reg & (~match_reg + QUEUE_DEPTH'(1));
            any_hit_reg <= |match_reg;
        end
        if (cmd.commit)
        begin
            status_code_reg <= mpi_umq_pkg::ST_NO_MATCH;
            found_reg       <= 1'b0;
            out_source_reg  <= '0;
            out_tag_reg     <= '0;
            out_bytes_reg   <= '0;
            copy_bytes_reg  <= '0;
            out_handle_reg  <= '0;
            if (is_insert)
            begin
                status_code_reg <= full ? mpi_umq_pkg::ST_FULL : mpi_umq_pkg::ST_OK;
            end
            else if (is_search && any_hit_reg)
            begin
                status_code_reg <= mpi_umq_pkg::ST_OK;
                found_reg       <= 1'b1;
                out_source_reg  <= sel_src;
                out_tag_reg     <= sel_tag;
                out_bytes_reg   <= sel_bytes;
                out_handle_reg  <= sel_handle;
                copy_bytes_reg  <= is_consume ? min_bytes : '0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_entry
            logic [mpi_umq_pkg::SRC_W-1:0]    up_src;
            logic [mpi_umq_pkg::TAG_W-1:0]    up_tag;
            logic [mpi_umq_pkg::COMM_W-1:0]   up_comm;
            logic [mpi_umq_pkg::BYTES_W-1:0]  up_bytes;
            logic [mpi_umq_pkg::HANDLE_W-1:0] up_handle;
            logic                             up_vld;

            if (g < QUEUE_DEPTH - 1)
            begin : g_mid
                assign up_src    = ent_src_reg[g+1];
                assign up_tag    = ent_tag_reg[g+1];
                assign up_comm   = ent_comm_reg[g+1];
                assign up_bytes  = ent_bytes_reg[g+1];
                assign up_handle = ent_handle_reg[g+1];
                assign up_vld    = vld_reg[g+1];
            end
            else
            begin : g_top
                assign up_src    = ent_src_reg[g];
                assign up_tag    = ent_tag_reg[g];
                assign up_comm   = ent_comm_reg[g];
                assign up_bytes  = ent_bytes_reg[g];
                assign up_handle = ent_handle_reg[g];
                assign up_vld    = 1'b0;
            end

            always_ff @(posedge clk)
            begin
                if (do_insert && cnt_reg == CW'(g))
                begin
                    ent_src_reg[g]    <= src_reg;
                    ent_tag_reg[g]    <= tag_reg;
                    ent_comm_reg[g]   <= comm_reg;
                    ent_bytes_reg[g]  <= mbytes_reg;
                    ent_handle_reg[g] <= handle_reg;
                end
                else if (do_remove && shift_mask[g])
                begin
                    ent_src_reg[g]    <= up_src;
                    ent_tag_reg[g]    <= up_tag;
                    ent_comm_reg[g]   <= up_comm;
                    ent_bytes_reg[g]  <= up_bytes;
                    ent_handle_reg[g] <= up_handle;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else if (do_insert && cnt_reg == CW'(g))
                begin
                    vld_reg[g] <= 1'b1;
                end
                else if (do_remove && shift_mask[g])
                begin
                    vld_reg[g] <= up_vld;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (do_insert)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        else if (do_remove)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    assign status_code = status_code_reg;
    assign found       = found_reg;
    assign out_source  = out_source_reg;
    assign out_tag     = out_tag_reg;
    assign out_bytes   = out_bytes_reg;
    assign copy_bytes  = copy_bytes_reg;
    assign out_handle  = out_handle_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_reg) == int'(cnt_reg))
        else $error("valid bits disagree with entry count");

endmodule

>>> sv/mpi_unexpected_message_match_queue.sv
// top level of the unexpected-message match queue
// usage:
//   a request (insert, probe or consume) is transferred at a rising edge with
//   start high and busy low; all request fields are sampled at that edge.
//   each request yields exactly one result, shown for one cycle with done high;
//   the receiver takes it at the edge that ends that cycle and cannot stall it.
// sequence, from the accepting edge to the edge that takes the result:
//   insert: the commit cycle, then the result cycle
//   probe / consume: match register, priority pick, commit, result
// requests are taken one at a time: busy stays high until the commit is done; a new request
//   may be transferred in the same cycle that the previous result is shown.
// the match compares all entries in parallel into a register, a one-hot pick
//   of the oldest hit follows, and the commit cycle reads the entry and, for a
//   consume, closes the gap by shifting younger entries down one place.
// reset: the queue comes up empty and idle; no clearing pass is needed.
module mpi_unexpected_message_match_queue #(
    parameter int QUEUE_DEPTH = mpi_umq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic [mpi_umq_pkg::OP_W-1:0]        operation,
    input  logic [mpi_umq_pkg::SRC_W-1:0]       src_rank,
    input  logic                                any_source,
    input  logic [mpi_umq_pkg::TAG_W-1:0]       tag_value,
    input  logic                                any_tag,
    input  logic [mpi_umq_pkg::COMM_W-1:0]      comm_id,
    input  logic [mpi_umq_pkg::BYTES_W-1:0]     msg_bytes,
    input  logic [mpi_umq_pkg::BYTES_W-1:0]     request_bytes,
    input  logic [mpi_umq_pkg::HANDLE_W-1:0]    payload_handle,
    output logic [mpi_umq_pkg::ST_W-1:0]        status_code,
    output logic                                found,
    output logic [mpi_umq_pkg::SRC_W-1:0]       out_source,
    output logic [mpi_umq_pkg::TAG_W-1:0]       out_tag,
    output logic [mpi_umq_pkg::BYTES_W-1:0]     out_bytes,
    output logic [mpi_umq_pkg::BYTES_W-1:0]     copy_bytes,
    output logic [mpi_umq_pkg::HANDLE_W-1:0]    out_handle
);

    mpi_umq_pkg::umq_cmd_t  cmd;
    mpi_umq_pkg::umq_stat_t stat;

    mpi_umq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mpi_umq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .operation      (operation),
        .src_rank       (src_rank),
        .any_source     (any_source),
        .tag_value      (tag_value),
        .any_tag        (any_tag),
        .comm_id        (comm_id),
        .msg_bytes      (msg_bytes),
        .request_bytes  (request_bytes),
        .payload_handle (payload_handle),
        .status_code    (status_code),
        .found          (found),
        .out_source     (out_source),
        .out_tag        (out_tag),
        .out_bytes      (out_bytes),
        .copy_bytes     (copy_bytes),
        .out_handle     (out_handle)
    );

endmodule
